// ===== design/badc_pkg.sv =====
// Shared constants for the bridge ADC serial reader.
`default_nettype none
package badc_pkg;

  localparam int DATA_W      = 24;
  localparam int DATA_PULSES = 24;
  localparam int GAIN_W      = 2;
  localparam int AVG_W       = 7;
  localparam int NET_W       = 25;

  localparam logic [1:0] KIND_TICK        = 2'd0;
  localparam logic [1:0] KIND_MEASURE     = 2'd1;
  localparam logic [1:0] KIND_TARE        = 2'd2;
  localparam logic [1:0] KIND_LOAD_OFFSET = 2'd3;

  localparam logic REG_GAIN_PULSES   = 1'b0;
  localparam logic REG_AVERAGE_COUNT = 1'b1;

endpackage
`default_nettype wire

// ===== design/bridge_adc_serial_reader_core.sv =====
// Bridge ADC serial reader: tick sequencer, averaging and offset handling.
// Usage:
//   Each input beat (in_valid/in_stall) is one half-period tick of the serial
//   clock, or a command: start measurement, start tare or load offset. Every
//   accepted beat yields exactly one output beat (out_valid/out_stall) that
//   carries the clock level for that tick, the busy flag and, on the tick
//   that completes a job, the averaged result.
//   An ordinary tick appears in the output register in the cycle after it
//   is accepted. The tick that completes a measurement or tare starts the
//   shared bit-serial divider, and that beat comes out only once the
//   divider is done and the output register is free; in_stall stays high
//   meanwhile. Other ticks are taken one per cycle while the output is free.
//   Configuration (cfg_write/cfg_index/cfg_data) is registered and
//   should only change while no job is in flight.
//   Reset clears the sequencer, the sum, the stored offset and sets
//   gain_pulses and average_count to 1.
//   When out_stall holds a filled output register, in_stall rises and no
//   new tick is taken until the beat drains.
`default_nettype none
module bridge_adc_serial_reader_core #(
  parameter int MAX_AVERAGE = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic                                 cfg_index,
  input  wire logic [badc_pkg::AVG_W-1:0]           cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           kind,
  input  wire logic                                 dout_level,
  input  wire logic signed [badc_pkg::DATA_W-1:0]   offset_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      sck_level,
  output logic                                      busy_res,
  output logic                                      result_valid,
  output logic                                      result_is_tare,
  output logic signed [badc_pkg::NET_W-1:0]         net_value
);
  import badc_pkg::*;

  localparam int CNT_W = $clog2(MAX_AVERAGE + 1);
  localparam int SUM_W = DATA_W + CNT_W;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_SHIFT = 2'd2;

  localparam logic [1:0] CTL_RUN = 2'd0;
  localparam logic [1:0] CTL_DIV = 2'd1;
  localparam logic [1:0] CTL_OUT = 2'd2;

  // configuration
  logic [GAIN_W-1:0] gain_pulses;
  logic [AVG_W-1:0]  average_count;

  // sequencer state
  logic [1:0]               ctl;
  logic [1:0]               phase;
  logic                     sck_out;
  logic [4:0]               pulse_count;
  logic [DATA_W-1:0]        shift_word;
  logic signed [SUM_W-1:0]  running_sum;
  logic [CNT_W-1:0]         readings_done;
  logic signed [DATA_W-1:0] stored_offset;
  logic                     tare_request;
  logic                     pend_tare;

  logic [1:0]               phase_next;
  logic                     sck_next;
  logic [4:0]               pulse_count_next;
  logic [DATA_W-1:0]        shift_word_next;
  logic signed [SUM_W-1:0]  running_sum_next;
  logic [CNT_W-1:0]         readings_done_next;
  logic signed [DATA_W-1:0] stored_offset_next;
  logic                     tare_request_next;
  logic                     finish;

  logic                     accept;
  logic                     out_free;
  logic                     load_out;
  logic [4:0]               pulse_inc;
  logic [5:0]               pulse_total;
  logic [7:0]               eff_wide;
  logic [CNT_W-1:0]         eff;
  logic signed [SUM_W-1:0]  reading_ext;
  logic                     div_done;
  logic signed [DATA_W-1:0] avg;

  assign out_free = !(out_valid && out_stall);
  assign in_stall = (ctl != CTL_RUN) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign load_out = (accept && !finish) || (ctl == CTL_OUT && out_free);

  assign pulse_inc   = pulse_count + 5'd1;
  assign pulse_total = 6'(DATA_PULSES) + 6'(gain_pulses);
  assign reading_ext = SUM_W'($signed(shift_word));

  // clamp the live average count to 1..MAX_AVERAGE
  always_comb begin
    if (average_count == '0) begin
      eff_wide = 8'd1;
    end else if ({1'b0, average_count} > 8'(MAX_AVERAGE)) begin
      eff_wide = 8'(MAX_AVERAGE);
    end else begin
      eff_wide = {1'b0, average_count};
    end
    eff = eff_wide[CNT_W-1:0];
  end

  always_comb begin
    phase_next         = phase;
    sck_next           = sck_out;
    pulse_count_next   = pulse_count;
    shift_word_next    = shift_word;
    running_sum_next   = running_sum;
    readings_done_next = readings_done;
    tare_request_next  = tare_request;
    finish             = 1'b0;
    stored_offset_next = (kind == KIND_LOAD_OFFSET) ? offset_value : stored_offset;
    case (phase)
      PH_IDLE: begin
        sck_next = 1'b0;
        if (kind == KIND_MEASURE || kind == KIND_TARE) begin
          phase_next         = PH_WAIT;
          tare_request_next  = (kind == KIND_TARE);
          running_sum_next   = '0;
          readings_done_next = '0;
          pulse_count_next   = '0;
          shift_word_next    = '0;
        end
      end
      PH_WAIT: begin
        sck_next = 1'b0;
        if (!dout_level) begin
          phase_next       = PH_SHIFT;
          pulse_count_next = '0;
          shift_word_next  = '0;
        end
      end
      PH_SHIFT: begin
        if (!sck_out) begin
          sck_next         = 1'b1;
          pulse_count_next = pulse_inc;
          if (pulse_inc <= 5'(DATA_PULSES)) begin
            shift_word_next = {shift_word[DATA_W-2:0], dout_level};
          end
        end else begin
          sck_next = 1'b0;
          if ({1'b0, pulse_count} >= pulse_total) begin
            running_sum_next   = running_sum + reading_ext;
            readings_done_next = readings_done + 1'b1;
            pulse_count_next   = '0;
            if (readings_done_next >= eff) begin
              finish            = 1'b1;
              phase_next        = PH_IDLE;
              tare_request_next = 1'b0;
            end else begin
              phase_next = PH_WAIT;
            end
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  badc_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && finish),
    .dividend (running_sum_next),
    .divisor  (readings_done_next),
    .done     (div_done),
    .quotient (avg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_pulses   <= GAIN_W'(1);
      average_count <= AVG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN_PULSES:   gain_pulses   <= cfg_data[GAIN_W-1:0];
        REG_AVERAGE_COUNT: average_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl           <= CTL_RUN;
      phase         <= PH_IDLE;
      sck_out       <= 1'b0;
      pulse_count   <= '0;
      shift_word    <= '0;
      running_sum   <= '0;
      readings_done <= '0;
      stored_offset <= '0;
      tare_request  <= 1'b0;
      pend_tare     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (ctl)
        CTL_RUN: begin
          if (accept) begin
            phase         <= phase_next;
            sck_out       <= sck_next;
            pulse_count   <= pulse_count_next;
            shift_word    <= shift_word_next;
            running_sum   <= running_sum_next;
            readings_done <= readings_done_next;
            stored_offset <= stored_offset_next;
            tare_request  <= tare_request_next;
            if (finish) begin
              pend_tare <= tare_request;
              ctl       <= CTL_DIV;
            end
          end
        end
        CTL_DIV: begin
          if (div_done) begin
            ctl <= CTL_OUT;
          end
        end
        CTL_OUT: begin
          // hold the finished average until the output register frees up
          if (out_free) begin
            if (pend_tare) begin
              stored_offset <= avg;
            end
            ctl <= CTL_RUN;
          end
        end
        default: begin
          ctl <= CTL_RUN;
        end
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (ctl == CTL_RUN && accept && !finish) begin
      sck_level      <= sck_next;
      busy_res       <= (phase_next != PH_IDLE);
      result_valid   <= 1'b0;
      result_is_tare <= 1'b0;
      net_value      <= '0;
    end else if (ctl == CTL_OUT && out_free) begin
      sck_level      <= 1'b0;
      busy_res       <= 1'b0;
      result_valid   <= 1'b1;
      result_is_tare <= pend_tare;
      if (pend_tare) begin
        net_value <= NET_W'(avg);
      end else begin
        net_value <= NET_W'(avg) - NET_W'(stored_offset);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/badc_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module badc_div #(
  parameter int DIVIDEND_W = 31,
  parameter int DIVISOR_W  = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [DIVIDEND_W-1:0]  dividend,
  input  wire logic [DIVISOR_W-1:0]          divisor,
  output logic                               done,
  output logic signed [badc_pkg::DATA_W-1:0] quotient
);
  import badc_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                   running;
  logic [CNT_W-1:0]       count;
  logic [DIVISOR_W-1:0]   rem;
  logic [DIVISOR_W-1:0]   dvs;
  logic [DIVIDEND_W-1:0]  quo;
  logic                   neg;

  logic [DIVIDEND_W-1:0]  dvd_bits;
  logic [DIVIDEND_W-1:0]  dvd_mag;
  logic [DIVISOR_W:0]     partial;
  logic [DIVISOR_W:0]     diff;
  logic                   fits;
  logic [DATA_W-1:0]      mag;

  assign dvd_bits = dividend;
  assign dvd_mag  = dvd_bits[DIVIDEND_W-1] ? (~dvd_bits + 1'b1) : dvd_bits;
  assign partial  = {rem, quo[DIVIDEND_W-1]};
  assign diff     = partial - {1'b0, dvs};
  assign fits     = partial >= {1'b0, dvs};
  assign mag      = quo[DATA_W-1:0];
  assign quotient = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= !start && running && (count == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        count   <= CNT_W'(DIVIDEND_W);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dvd_mag;
      rem <= '0;
      dvs <= divisor;
      neg <= dvd_bits[DIVIDEND_W-1];
    end else if (running) begin
      // shift in one quotient bit, keep the partial remainder
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
    end
  end

endmodule
`default_nettype wire
